// ----- rtl/core/cle_pkg.sv -----
package cle_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_SORTED     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_REMOVE_EQ  = 3'd5
  } req_e;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_total;
    logic [4:0]         removed_total;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_RM_RD,
    S_RM_CHK,
    S_FRONT_RD,
    S_BACK_RD,
    S_REPORT
  } state_e;

endpackage

// ----- rtl/core/cle_ram.sv -----
module cle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/circular_list_engine.sv -----
// Push front/back pass through the place, front-read, back-read and report states; pops,
// refused inserts and unused request codes skip place. A sorted insert into a non-empty
// list and remove-all walk entries first, using the single read and single write port.
// One item at a time: busy stays high until the result strobe. The receiver cannot
// stall; out_valid lasts one cycle. Synchronous active-low reset empties the list (head
// and count to zero); the entry memory is not cleared, as only written slots are read.
module circular_list_engine #(
  parameter int unsigned CAPACITY = cle_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cle_pkg::in_item_t in_item,
  output logic              out_valid,
  output cle_pkg::out_item_t out_item
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  cle_pkg::state_e state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;   // scan / read index (logical)
  logic [CW-1:0]   wr_r, wr_nxt;     // write index / insert position
  logic [2:0]      req_r, req_nxt;
  logic [31:0]     val_r, val_nxt;
  logic [31:0]     hold_r, hold_nxt;
  logic [31:0]     front_r, front_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic [4:0]      rem_r, rem_nxt;
  logic            ovalid_r, ovalid_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wdata, rdata;
  logic [CW-1:0]   rd_log, wr_log;
  logic            scan_stop;

  cle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(i);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  // A value equal to the front entry goes in front of it; further on, equal values are
  // passed over so that the new one lands after them.
  assign scan_stop = ($signed(rdata) > $signed(val_r)) || (idx_r == '0 && rdata == val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cle_pkg::S_IDLE;
      head_r   <= '0;
      fill_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      ovalid_r <= ovalid_nxt;
    end
    idx_r   <= idx_nxt;
    wr_r    <= wr_nxt;
    req_r   <= req_nxt;
    val_r   <= val_nxt;
    hold_r  <= hold_nxt;
    front_r <= front_nxt;
    stat_r  <= stat_nxt;
    rem_r   <= rem_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cle_pkg::S_IDLE: begin
        if (start) begin
          if (in_item.req_type <= cle_pkg::REQ_SORTED && fill_r >= CW'(CAPACITY)) begin
            state_nxt = cle_pkg::S_FRONT_RD;
          end else if (in_item.req_type >= cle_pkg::REQ_POP_FRONT &&
                       in_item.req_type <= cle_pkg::REQ_REMOVE_EQ && fill_r == '0) begin
            state_nxt = cle_pkg::S_FRONT_RD;
          end else if (in_item.req_type == cle_pkg::REQ_SORTED && fill_r != '0) begin
            state_nxt = cle_pkg::S_SCAN_RD;
          end else if (in_item.req_type == cle_pkg::REQ_REMOVE_EQ) begin
            state_nxt = cle_pkg::S_RM_RD;
          end else if (in_item.req_type <= cle_pkg::REQ_SORTED) begin
            state_nxt = cle_pkg::S_PLACE;
          end else begin
            state_nxt = cle_pkg::S_FRONT_RD;
          end
        end
      end
      cle_pkg::S_SCAN_RD:  state_nxt = cle_pkg::S_SCAN_CHK;
      cle_pkg::S_SCAN_CHK: begin
        if (scan_stop || idx_r + 1'b1 >= fill_r) begin
          state_nxt = cle_pkg::S_SHIFT_RD;
        end else begin
          state_nxt = cle_pkg::S_SCAN_RD;
        end
      end
      cle_pkg::S_SHIFT_RD: state_nxt = (idx_r > wr_r) ? cle_pkg::S_SHIFT_WR : cle_pkg::S_PLACE;
      cle_pkg::S_SHIFT_WR: state_nxt = cle_pkg::S_SHIFT_RD;
      cle_pkg::S_PLACE:    state_nxt = cle_pkg::S_FRONT_RD;
      cle_pkg::S_RM_RD:    state_nxt = (idx_r < fill_r) ? cle_pkg::S_RM_CHK : cle_pkg::S_FRONT_RD;
      cle_pkg::S_RM_CHK:   state_nxt = cle_pkg::S_RM_RD;
      cle_pkg::S_FRONT_RD: state_nxt = cle_pkg::S_BACK_RD;
      cle_pkg::S_BACK_RD:  state_nxt = cle_pkg::S_REPORT;
      cle_pkg::S_REPORT:   state_nxt = cle_pkg::S_IDLE;
      default:             state_nxt = cle_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    wr_nxt     = wr_r;
    req_nxt    = req_r;
    val_nxt    = val_r;
    hold_nxt   = hold_r;
    front_nxt  = front_r;
    stat_nxt   = stat_r;
    rem_nxt    = rem_r;
    ovalid_nxt = 1'b0;
    we         = 1'b0;
    rd_log     = idx_r;
    wr_log     = wr_r;
    wdata      = val_r;
    unique case (state_r)
      cle_pkg::S_IDLE: begin
        req_nxt  = in_item.req_type;
        val_nxt  = in_item.item_value;
        stat_nxt = cle_pkg::ST_DONE;
        rem_nxt  = '0;
        idx_nxt  = '0;
        wr_nxt   = '0;
        if (start) begin
          if (in_item.req_type <= cle_pkg::REQ_SORTED && fill_r >= CW'(CAPACITY)) begin
            stat_nxt = cle_pkg::ST_FULL;
          end else if (in_item.req_type >= cle_pkg::REQ_POP_FRONT &&
                       in_item.req_type <= cle_pkg::REQ_REMOVE_EQ && fill_r == '0) begin
            stat_nxt = cle_pkg::ST_EMPTY;
          end else begin
            unique case (in_item.req_type)
              cle_pkg::REQ_PUSH_FRONT: begin
                head_nxt = (head_r == '0) ? AW'(CAPACITY - 1) : head_r - 1'b1;
                idx_nxt  = fill_r;   // nothing to shift
                wr_nxt   = '0;
              end
              cle_pkg::REQ_PUSH_BACK: begin
                idx_nxt = fill_r;
                wr_nxt  = fill_r;
              end
              cle_pkg::REQ_SORTED: begin
                idx_nxt = '0;
                wr_nxt  = '0;
              end
              cle_pkg::REQ_POP_FRONT: begin
                head_nxt = slot(head_r, CW'(1));
                fill_nxt = fill_r - 1'b1;
                rem_nxt  = 5'd1;
                if (fill_r == CW'(1)) head_nxt = '0;
              end
              cle_pkg::REQ_POP_BACK: begin
                fill_nxt = fill_r - 1'b1;
                rem_nxt  = 5'd1;
                if (fill_r == CW'(1)) head_nxt = '0;
              end
              default: ;
            endcase
          end
        end
      end
      cle_pkg::S_SCAN_RD: begin
        rd_log = idx_r;
      end
      cle_pkg::S_SCAN_CHK: begin
        if (scan_stop) begin
          // stop: insert at idx_r (front if idx_r is zero)
          wr_nxt  = idx_r;
          idx_nxt = fill_r;
        end else if (idx_r + 1'b1 >= fill_r) begin
          wr_nxt  = fill_r;
          idx_nxt = fill_r;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      cle_pkg::S_SHIFT_RD: begin
        rd_log = idx_r - 1'b1;
      end
      cle_pkg::S_SHIFT_WR: begin
        we      = 1'b1;
        wr_log  = idx_r;
        wdata   = rdata;
        idx_nxt = idx_r - 1'b1;
      end
      cle_pkg::S_PLACE: begin
        we       = 1'b1;
        wr_log   = wr_r;
        wdata    = val_r;
        fill_nxt = fill_r + 1'b1;
      end
      cle_pkg::S_RM_RD: begin
        rd_log = idx_r;
        if (idx_r >= fill_r) begin
          rem_nxt  = 5'(fill_r - wr_r);
          fill_nxt = wr_r;
          if (wr_r == '0) head_nxt = '0;
        end
      end
      cle_pkg::S_RM_CHK: begin
        idx_nxt = idx_r + 1'b1;
        if (rdata != val_r) begin
          we     = 1'b1;
          wr_log = wr_r;
          wdata  = rdata;
          wr_nxt = wr_r + 1'b1;
        end
      end
      cle_pkg::S_FRONT_RD: begin
        rd_log = '0;
      end
      cle_pkg::S_BACK_RD: begin
        rd_log    = fill_r - 1'b1;
        front_nxt = rdata;
      end
      cle_pkg::S_REPORT: begin
        hold_nxt   = rdata;
        ovalid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign raddr = slot(head_r, rd_log);
  assign waddr = slot(head_r, wr_log);

  always_comb begin
    busy                   = (state_r != cle_pkg::S_IDLE);
    out_valid              = ovalid_r;
    out_item.status        = stat_r;
    out_item.entry_total   = 5'(fill_r);
    out_item.removed_total = rem_r;
    out_item.front_value   = (fill_r == '0) ? '0 : front_r;
    out_item.back_value    = (fill_r == '0) ? '0 : hold_r;
  end

endmodule

// ----- sim/tb_circular_list_engine.sv -----
`timescale 1ns / 1ps

module tb_circular_list_engine;
  import cle_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  // Request codes the block does not use; it must report the list unchanged.
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  logic signed [31:0] list_vals[$];
  out_item_t          pending_results[$];
  stim_row_t          directed_rows[$];
  int                 fail_count;
  bit                 idle_on;

  circular_list_engine #(.CAPACITY(CAP)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Applies one request to the list kept here and returns the report it yields.
  function automatic out_item_t apply_list_request(input in_item_t it);
    out_item_t r;
    int pos;
    int i;
    int n;
    logic signed [31:0] kept[$];
    r = '0;
    n = list_vals.size();
    case (it.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_SORTED: begin
        if (n >= CAP) begin
          r.status = ST_FULL;
        end else if (it.req_type == REQ_PUSH_FRONT) begin
          list_vals.push_front(it.item_value);
        end else if (it.req_type == REQ_PUSH_BACK) begin
          list_vals.push_back(it.item_value);
        end else begin
          pos = 0;
          if (n > 0 && list_vals[0] < it.item_value) begin
            i = 0;
            while (i + 1 < n && list_vals[i + 1] <= it.item_value) i++;
            pos = i + 1;
          end
          list_vals.insert(pos, it.item_value);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE_EQ: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (it.req_type == REQ_POP_FRONT) begin
          void'(list_vals.pop_front());
          r.removed_total = 1;
        end else if (it.req_type == REQ_POP_BACK) begin
          void'(list_vals.pop_back());
          r.removed_total = 1;
        end else begin
          foreach (list_vals[k]) if (list_vals[k] != it.item_value) kept.push_back(list_vals[k]);
          r.removed_total = 5'(n - kept.size());
          list_vals = kept;
        end
      end
      default: ;
    endcase
    r.entry_total = 5'(list_vals.size());
    if (list_vals.size() > 0) begin
      r.front_value = list_vals[0];
      r.back_value  = list_vals[$];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t result with no request outstanding", $realtime);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (out_item.entry_total !== want.entry_total)
          report_mismatch("entry_total", 32'(out_item.entry_total), 32'(want.entry_total));
        if (out_item.removed_total !== want.removed_total)
          report_mismatch("removed_total", 32'(out_item.removed_total),
                          32'(want.removed_total));
        if (out_item.front_value !== want.front_value)
          report_mismatch("front_value", out_item.front_value, want.front_value);
        if (out_item.back_value !== want.back_value)
          report_mismatch("back_value", out_item.back_value, want.back_value);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input in_item_t it, input bit typed, input out_item_t typed_res);
    int gap;
    out_item_t predicted;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predicted = apply_list_request(it);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic add_row(input logic [2:0] req, input logic signed [31:0] v, input bit typed,
                         input logic [1:0] st, input int total, input int removed,
                         input logic signed [31:0] front, input logic signed [31:0] back);
    stim_row_t row;
    row.item.req_type           = req;
    row.item.item_value         = v;
    row.typed                   = typed;
    row.result.status           = st;
    row.result.entry_total      = 5'(total);
    row.result.removed_total    = 5'(removed);
    row.result.front_value      = front;
    row.result.back_value       = back;
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 32'($signed($urandom_range(0, 6)) - 3);
      6: return 32'h7fff_ffff;
      7: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    in_item_t  it;
    out_item_t none;
    bit        growing;
    int        r;
    clk        = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    fail_count = 0;
    idle_on    = 1'b0;
    none       = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    add_row(REQ_POP_FRONT, 0, 1, ST_EMPTY, 0, 0, 0, 0);
    add_row(REQ_POP_BACK, 0, 1, ST_EMPTY, 0, 0, 0, 0);
    add_row(REQ_REMOVE_EQ, 0, 1, ST_EMPTY, 0, 0, 0, 0);
    add_row(REQ_SPARE_6, 32'hffff_ffff, 1, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_PUSH_FRONT, 32'h7fff_ffff, 1, ST_DONE, 1, 0, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(REQ_PUSH_BACK, 32'h8000_0000, 1, ST_DONE, 2, 0, 32'h7fff_ffff, 32'h8000_0000);
    add_row(REQ_POP_BACK, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_SORTED, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_SORTED, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_SORTED, 32'h8000_0000, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_SORTED, 5, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_SORTED, -1, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_REMOVE_EQ, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_REMOVE_EQ, 9, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_SPARE_7, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_PUSH_FRONT, -7, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_POP_FRONT, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_POP_BACK, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_POP_FRONT, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_POP_FRONT, 0, 0, ST_DONE, 0, 0, 0, 0);
    add_row(REQ_POP_BACK, 0, 0, ST_DONE, 0, 0, 0, 0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

    // Alternate filling and draining spells so the full and empty edges are met often.
    growing = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (list_vals.size() >= CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (list_vals.size() == 0 && $urandom_range(0, 1) == 0) growing = 1'b1;
      if ($urandom_range(0, 59) == 0) growing = ~growing;
      r = $urandom_range(0, 99);
      it.item_value = pick_value();
      if (r < 3) begin
        it.req_type = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
      end else if (growing ? r < 75 : r < 25) begin
        case ($urandom_range(0, 3))
          0: it.req_type = REQ_PUSH_FRONT;
          1: it.req_type = REQ_PUSH_BACK;
          default: it.req_type = REQ_SORTED;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: it.req_type = REQ_POP_FRONT;
          1: it.req_type = REQ_POP_BACK;
          default: begin
            it.req_type = REQ_REMOVE_EQ;
            if (list_vals.size() > 0 && $urandom_range(0, 2) != 0)
              it.item_value = list_vals[$urandom_range(0, list_vals.size() - 1)];
          end
        endcase
      end
      send_request(it, 1'b0, none);
    end
    start = 1'b0;

    wait (pending_results.size() == 0);
    repeat (3 * CAP + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
